>>> rtl/core/mq2s_pkg.sv
// Package for the two-stack min queue: sizes, beat payload types,
// stack entry type and the command and status structs between controller and datapath.
// Used by every module of the block except the generic RAM.
`default_nettype none

package mq2s_pkg;

	localparam int DEPTH  = 1024;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int HELD_W = 12;

	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	typedef struct packed {
		logic                     req_type;
		logic signed [DATA_W-1:0] data_value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] dequeued_value;
		logic signed [DATA_W-1:0] queue_min;
		logic [HELD_W-1:0]        held_count;
		logic                     is_empty;
		logic                     op_error;
	} rsp_t;

	// One stack slot: the value and the running minimum at that slot.
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] run_min;
	} entry_t;

	typedef struct packed {
		logic start;       // clear per-request result registers
		logic set_err;
		logic push;        // write input stack top
		logic in_rd;       // read input stack top
		logic xfer_wr;     // move read value onto output stack
		logic out_rd_top;  // read output stack top
		logic pop;         // take top value, drop output count
		logic out_rd_next; // read entry below the popped one
		logic load_min;    // refresh output stack minimum
		logic emit;        // load result register
	} cmd_t;

	typedef struct packed {
		logic in_empty;
		logic in_full;
		logic in_last;
		logic out_empty;
		logic out_multi;
		logic res_busy;
	} status_t;

endpackage

`default_nettype wire

>>> rtl/core/mq2s_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mq2s_ram #(
	parameter  int DATA_W = 64,
	parameter  int WORDS  = 1024,
	localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/mq2s_dpath.sv
// Datapath of the two-stack min queue: stack RAMs, counters, top minima
// and the result register. Depends on mq2s_pkg and mq2s_ram.
`default_nettype none

module mq2s_dpath
	import mq2s_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire req_t    req,
	input  wire cmd_t    cmd,
	output status_t      status,
	output logic         rsp_valid,
	input  wire logic    rsp_stall,
	output rsp_t         rsp
);

	logic [CNT_W-1:0]         in_count_q;
	logic [CNT_W-1:0]         out_count_q;
	logic signed [DATA_W-1:0] in_min_q;
	logic signed [DATA_W-1:0] out_min_q;
	logic signed [DATA_W-1:0] deq_q;
	logic                     err_q;
	logic                     res_valid_q;
	rsp_t                     rsp_q;

	entry_t in_wr, in_rd, out_wr, out_rd;
	logic [CNT_W-1:0]  in_top, out_top, out_below;
	logic [ADDR_W-1:0] out_raddr;
	logic signed [DATA_W-1:0] push_min, xfer_min, cur_min;
	logic [HELD_W-1:0] held;

	assign in_top    = in_count_q - CNT_W'(1);
	assign out_top   = out_count_q - CNT_W'(1);
	assign out_below = out_count_q - CNT_W'(2);

	assign push_min = (in_count_q == '0) ? req.data_value
		: ((req.data_value < in_min_q) ? req.data_value : in_min_q);
	assign in_wr = '{value: req.data_value, run_min: push_min};

	assign xfer_min = (out_count_q == '0) ? in_rd.value
		: ((in_rd.value < out_min_q) ? in_rd.value : out_min_q);
	assign out_wr = '{value: in_rd.value, run_min: xfer_min};

	assign out_raddr = cmd.out_rd_next ? out_below[ADDR_W-1:0] : out_top[ADDR_W-1:0];

	mq2s_ram #(.DATA_W($bits(entry_t)), .WORDS(DEPTH)) u_in_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (in_count_q[ADDR_W-1:0]),
		.wdata (in_wr),
		.re    (cmd.in_rd),
		.raddr (in_top[ADDR_W-1:0]),
		.rdata (in_rd)
	);

	mq2s_ram #(.DATA_W($bits(entry_t)), .WORDS(DEPTH)) u_out_ram (
		.clk   (clk),
		.we    (cmd.xfer_wr),
		.waddr (out_count_q[ADDR_W-1:0]),
		.wdata (out_wr),
		.re    (cmd.out_rd_top | cmd.out_rd_next),
		.raddr (out_raddr),
		.rdata (out_rd)
	);

	always_comb begin
		if (in_count_q == '0 && out_count_q == '0) begin
			cur_min = '0;
		end else if (out_count_q == '0) begin
			cur_min = in_min_q;
		end else if (in_count_q == '0) begin
			cur_min = out_min_q;
		end else begin
			cur_min = (in_min_q < out_min_q) ? in_min_q : out_min_q;
		end
	end

	assign held = HELD_W'(in_count_q) + HELD_W'(out_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_count_q  <= '0;
			out_count_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				in_count_q <= in_count_q + CNT_W'(1);
			end
			if (cmd.xfer_wr) begin
				in_count_q  <= in_count_q - CNT_W'(1);
				out_count_q <= out_count_q + CNT_W'(1);
			end
			if (cmd.pop) begin
				out_count_q <= out_count_q - CNT_W'(1);
			end
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			deq_q <= '0;
			err_q <= 1'b0;
		end
		if (cmd.set_err) begin
			err_q <= 1'b1;
		end
		if (cmd.push) begin
			in_min_q <= push_min;
		end
		if (cmd.xfer_wr) begin
			out_min_q <= xfer_min;
		end
		if (cmd.pop) begin
			deq_q <= out_rd.value;
		end
		if (cmd.load_min) begin
			out_min_q <= out_rd.run_min;
		end
		if (cmd.emit) begin
			rsp_q.dequeued_value <= deq_q;
			rsp_q.queue_min      <= cur_min;
			rsp_q.held_count     <= held;
			rsp_q.is_empty       <= (held == '0);
			rsp_q.op_error       <= err_q;
		end
	end

	assign status.in_empty  = (in_count_q == '0);
	assign status.in_full   = (in_count_q == CNT_W'(DEPTH));
	assign status.in_last   = (in_count_q == CNT_W'(1));
	assign status.out_empty = (out_count_q == '0);
	assign status.out_multi = (out_count_q > CNT_W'(1));
	assign status.res_busy  = res_valid_q & rsp_stall;

	assign rsp_valid = res_valid_q;
	assign rsp       = rsp_q;

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(HELD_W'(in_count_q) + HELD_W'(out_count_q)) <= HELD_W'(2 * DEPTH))
		else $error("stack counts exceed capacity");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !res_valid_q)
		else $error("result loaded over an untaken beat");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> (in_count_q == $past(in_count_q) + CNT_W'(1)) && (in_count_q != '0))
		else $error("push did not advance input count");

	a_xfer_src: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.xfer_wr || cmd.in_rd) |-> !status.in_empty)
		else $error("transfer from empty input stack");

endmodule

`default_nettype wire

>>> rtl/core/mq2s_ctrl.sv
// Controller of the two-stack min queue: sequences enqueue, transfer and
// dequeue steps and issues commands to the datapath. Depends on mq2s_pkg.
`default_nettype none

module mq2s_ctrl
	import mq2s_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	input  wire logic    req_type,
	output logic         req_stall,
	input  wire status_t status,
	output cmd_t         cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_XFER_RD,
		S_XFER_WR,
		S_POP_RD,
		S_POP_TOP,
		S_POP_MIN,
		S_RESP
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign req_stall = (state_q != S_IDLE) | status.res_busy;
	assign accept    = req_valid & ~req_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.start = 1'b1;
					if (req_type == REQ_ENQ) begin
						if (status.in_full) begin
							cmd.set_err = 1'b1;
						end else begin
							cmd.push = 1'b1;
						end
						state_d = S_RESP;
					end else if (status.in_empty && status.out_empty) begin
						cmd.set_err = 1'b1;
						state_d     = S_RESP;
					end else if (status.out_empty) begin
						state_d = S_XFER_RD;
					end else begin
						state_d = S_POP_RD;
					end
				end
			end
			S_XFER_RD: begin
				cmd.in_rd = 1'b1;
				state_d   = S_XFER_WR;
			end
			S_XFER_WR: begin
				cmd.xfer_wr = 1'b1;
				state_d     = status.in_last ? S_POP_RD : S_XFER_RD;
			end
			S_POP_RD: begin
				cmd.out_rd_top = 1'b1;
				state_d        = S_POP_TOP;
			end
			S_POP_TOP: begin
				cmd.pop = 1'b1;
				// fetch the new top's minimum only if something stays behind
				if (status.out_multi) begin
					cmd.out_rd_next = 1'b1;
					state_d         = S_POP_MIN;
				end else begin
					state_d = S_RESP;
				end
			end
			S_POP_MIN: begin
				cmd.load_min = 1'b1;
				state_d      = S_RESP;
			end
			S_RESP: begin
				cmd.emit = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/min_queue_two_stacks.sv
// Min queue built from two stacks. Enqueue or refused request: accept, then
// result beat. Dequeue from a filled output stack: read top, pop, reload the
// minimum if entries remain. A dequeue that finds the output stack empty first
// moves each input value by a read then a write step (registered RAM read).
// One request is in flight at a time. Reset clears counts and control only;
// stack RAM contents are not cleared and no clearing pass runs.
`default_nettype none

module min_queue_two_stacks
	import mq2s_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	cmd_t    cmd;
	status_t status;

	mq2s_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	mq2s_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

>>> tb/tb_min_queue_two_stacks.sv
// Self-checking testbench for the two-stack min queue: drives request beats,
// predicts every response in SystemVerilog and compares it field by field.
// Depends on mq2s_pkg and the min_queue_two_stacks top level.
`timescale 1ns / 1ps

module tb_min_queue_two_stacks;
	import mq2s_pkg::*;

	localparam int LONG_HOLD   = 400;
	localparam int TAIL_CYCLES = 50;
	localparam int CMP_W       = DATA_W + 1;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic rsp_stall = 1'b0;
	req_t req       = '0;
	logic req_stall;
	logic rsp_valid;
	rsp_t rsp;

	min_queue_two_stacks dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Request beats waiting to be offered, and responses predicted from accepted beats.
	req_t pending_q[$];
	rsp_t expected_rsp_q[$];

	int send_idle_pct  = 0;
	int rsp_stall_pct  = 0;
	int long_hold_left = 0;
	bit sender_hold    = 1'b0;

	int n_accepted = 0;
	int n_refused  = 0;
	int n_results  = 0;
	int err_count  = 0;

	// Shadow copy of both stacks for the predictor.
	logic signed [DATA_W-1:0] in_vals  [DEPTH];
	logic signed [DATA_W-1:0] in_mins  [DEPTH];
	logic signed [DATA_W-1:0] out_vals [DEPTH];
	logic signed [DATA_W-1:0] out_mins [DEPTH];
	int unsigned in_depth  = 0;
	int unsigned out_depth = 0;

	// Stack occupancy as the stimulus generator sees it, used to shape sequences.
	int unsigned gen_in  = 0;
	int unsigned gen_out = 0;

	function automatic logic signed [DATA_W-1:0] smaller(input logic signed [DATA_W-1:0] a,
			input logic signed [DATA_W-1:0] b);
		return (b < a) ? b : a;
	endfunction

	function automatic rsp_t predict_queue_op(input req_t r);
		rsp_t o;
		logic signed [DATA_W-1:0] v;
		int unsigned held;
		o = '0;
		if (r.req_type == REQ_ENQ) begin
			if (in_depth >= DEPTH) begin
				o.op_error = 1'b1;
			end else begin
				in_vals[in_depth] = r.data_value;
				in_mins[in_depth] = (in_depth == 0) ? r.data_value :
					smaller(in_mins[in_depth-1], r.data_value);
				in_depth++;
			end
		end else begin
			if (in_depth == 0 && out_depth == 0) begin
				o.op_error = 1'b1;
			end else begin
				// Refill the output stack in reverse order, rebuilding its minima.
				if (out_depth == 0) begin
					while (in_depth > 0) begin
						in_depth--;
						v = in_vals[in_depth];
						out_vals[out_depth] = v;
						out_mins[out_depth] = (out_depth == 0) ? v :
							smaller(out_mins[out_depth-1], v);
						out_depth++;
					end
				end
				out_depth--;
				o.dequeued_value = out_vals[out_depth];
			end
		end
		held = in_depth + out_depth;
		if (held == 0)
			o.queue_min = '0;
		else if (out_depth == 0)
			o.queue_min = in_mins[in_depth-1];
		else if (in_depth == 0)
			o.queue_min = out_mins[out_depth-1];
		else
			o.queue_min = smaller(in_mins[in_depth-1], out_mins[out_depth-1]);
		o.held_count = held[HELD_W-1:0];
		o.is_empty   = (held == 0);
		return o;
	endfunction

	// Request driver: when the slot frees up, offer the next pending beat unless held or idling at random.
	always @(posedge clk or negedge arst_n) begin : req_driver
		rsp_t pred;
		req_t nxt;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				pred = predict_queue_op(req);
				expected_rsp_q.push_back(pred);
				n_accepted++;
				if (pred.op_error)
					n_refused++;
			end
			if (!req_valid || !req_stall) begin
				if (sender_hold || pending_q.size() == 0 ||
						$urandom_range(99) < send_idle_pct) begin
					req_valid <= 1'b0;
				end else begin
					nxt = pending_q.pop_front();
					req       <= nxt;
					req_valid <= 1'b1;
				end
			end
		end
	end

	task automatic cmp_field(input string name, input logic signed [CMP_W-1:0] want,
			input logic signed [CMP_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	// Response monitor and stall generator.
	always @(posedge clk or negedge arst_n) begin : rsp_monitor
		rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				n_results++;
				if (expected_rsp_q.size() == 0) begin
					$error("response beat with no request outstanding");
					err_count++;
				end else begin
					want = expected_rsp_q.pop_front();
					cmp_field("dequeued_value", CMP_W'(want.dequeued_value),
						CMP_W'(rsp.dequeued_value));
					cmp_field("queue_min", CMP_W'(want.queue_min),
						CMP_W'(rsp.queue_min));
					cmp_field("held_count", CMP_W'(want.held_count),
						CMP_W'(rsp.held_count));
					cmp_field("is_empty", CMP_W'(want.is_empty),
						CMP_W'(rsp.is_empty));
					cmp_field("op_error", CMP_W'(want.op_error),
						CMP_W'(rsp.op_error));
				end
			end
			if (long_hold_left > 0) begin
				long_hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
			end
		end
	end

	function automatic logic signed [DATA_W-1:0] rand_value();
		case ($urandom_range(7))
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2, 3:    return $signed(32'($urandom_range(15))) - 8;
			default: return $signed($urandom);
		endcase
	endfunction

	task automatic push_enq(input logic signed [DATA_W-1:0] v);
		req_t r;
		r.req_type   = REQ_ENQ;
		r.data_value = v;
		pending_q.push_back(r);
		if (gen_in < DEPTH)
			gen_in++;
	endtask

	task automatic push_deq();
		req_t r;
		r.req_type   = REQ_DEQ;
		r.data_value = $signed($urandom);
		pending_q.push_back(r);
		if (gen_in + gen_out != 0) begin
			if (gen_out == 0) begin
				gen_out = gen_in;
				gen_in  = 0;
			end
			gen_out--;
		end
	endtask

	// Mixed traffic that keeps the queue shallow, with the odd dequeue on empty.
	task automatic random_burst(input int n);
		int p_enq;
		int held;
		for (int i = 0; i < n; i++) begin
			held = gen_in + gen_out;
			if (held < 4)
				p_enq = 70;
			else if (held > 24)
				p_enq = 30;
			else
				p_enq = 52;
			if ($urandom_range(99) < p_enq)
				push_enq(rand_value());
			else
				push_deq();
		end
	endtask

	task automatic wait_all_accepted();
		while (pending_q.size() != 0 || req_valid)
			@(posedge clk);
	endtask

	task automatic wait_all_results();
		wait_all_accepted();
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
		@(negedge clk);
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		random_burst(n);
		wait_all_accepted();
	endtask

	initial begin : stimulus
		int n_drain;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed: empty refusals, extreme values, ties and an interleaved refill.
		push_deq();
		push_enq(32'sh7FFF_FFFF);
		push_enq(32'sh8000_0000);
		push_enq(32'sh0);
		push_enq(-32'sh1);
		push_enq(32'sh1);
		push_deq();
		push_enq(32'sh8000_0000);
		repeat (6) push_deq();
		push_deq();
		push_enq(32'sh5);
		push_enq(32'sh3);
		push_enq(32'sh7);
		push_deq();
		push_enq(32'sh2);
		repeat (3) push_deq();
		wait_all_results();

		run_phase(0, 0, 240);
		run_phase(75, 0, 190);
		run_phase(0, 75, 190);
		run_phase(38, 38, 190);

		// Pause the sender until everything has come back.
		@(negedge clk) sender_hold = 1'b1;
		wait_all_results();
		repeat (10) @(posedge clk);
		@(negedge clk) sender_hold = 1'b0;

		// Hold off responses for a long stretch while requests keep coming.
		@(negedge clk);
		send_idle_pct  = 0;
		rsp_stall_pct  = 0;
		long_hold_left = LONG_HOLD;
		random_burst(30);
		while (long_hold_left != 0)
			@(posedge clk);
		wait_all_accepted();

		// Empty the queue, fill the input stack past its end, then one long refill.
		@(negedge clk);
		send_idle_pct = 38;
		rsp_stall_pct = 38;
		n_drain = gen_in + gen_out;
		repeat (n_drain + 1) push_deq();
		repeat (DEPTH + 2) push_enq(rand_value());
		push_deq();
		random_burst(20);
		wait_all_results();

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Ran %0d requests (%0d refused) and checked %0d responses,",
			n_accepted, n_refused, n_results);
		$display("over four idling mixes, a long response hold-off and a full input stack.");
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("Run timed out with %0d responses outstanding", expected_rsp_q.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
